FILE: hdl/cssc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cssc_pkg: shared types, constants and the coloring function
// Holds the scanner state type, the result item type, the color attribute
// codes and the per-byte coloring function used by the colorizer.
// ============================================================================
package cssc_pkg;

    // Default number of result entries queued at the output.
    localparam int RESULT_DEPTH = 4;

    // Console color attribute codes.
    localparam logic [3:0] ATTR_DEFAULT  = 4'h7;
    localparam logic [3:0] ATTR_OPERATOR = 4'hC;
    localparam logic [3:0] ATTR_BRACKET  = 4'hE;
    localparam logic [3:0] ATTR_DIGIT    = 4'hF;
    localparam logic [3:0] ATTR_PREPROC  = 4'hD;
    localparam logic [3:0] ATTR_CHAR     = 4'hA;
    localparam logic [3:0] ATTR_STRING   = 4'h6;
    localparam logic [3:0] ATTR_COMMENT  = 4'h2;
    localparam logic [3:0] ATTR_IDENT    = 4'hB;

    // Byte codes with a special meaning to the scanner.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NONE    = 8'h00;

    // Lexical state carried from one byte to the next.
    typedef struct packed {
        logic at_row_start;
        logic preproc_row;
        logic char_open;
        logic string_open;
        logic block_open;
        logic line_active;
        logic close_next;
    } t_scan;

    localparam t_scan SCAN_RESET = '{
        at_row_start: 1'b1, preproc_row: 1'b0, char_open: 1'b0, string_open: 1'b0,
        block_open: 1'b0, line_active: 1'b0, close_next: 1'b0
    };

    // Outcome of coloring one byte: its attribute and the state after it.
    typedef struct packed {
        t_scan      state;
        logic [3:0] attr;
    } t_colour;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0] colored_byte;
        logic [3:0] attribute;
        logic       final_result;
    } t_result;

    // Colors byte b given its successor nxt and the state before it.
    // Later rules override earlier ones, as in the color priority list.
    function automatic t_colour colour_byte(input logic [7:0] b, input logic [7:0] nxt,
                                            input t_scan s);
        t_colour    r;
        logic [3:0] col;
        logic       not_last;
        logic       closing;
        r        = '{state: s, attr: ATTR_DEFAULT};
        col      = ATTR_DEFAULT;
        not_last = (b != CH_NEWLINE);
        closing  = s.close_next;

        if (s.at_row_start) begin
            r.state.preproc_row = (b == CH_HASH);
        end
        r.state.at_row_start = (b == CH_NEWLINE);

        // Operators: ! % & * + , - . / : ; < = > ? ^ | ~
        if (b inside {8'h21, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
                      8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5E, 8'h7C, 8'h7E}) begin
            col = ATTR_OPERATOR;
        end else if (b inside {8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D}) begin
            col = ATTR_BRACKET;
        end else if (b inside {[8'h30:8'h39]}) begin
            col = ATTR_DIGIT;
        end

        if (r.state.preproc_row && b == CH_LESS) begin
            r.state.preproc_row = 1'b0;
        end
        if (r.state.preproc_row) begin
            col = ATTR_PREPROC;
        end

        if (b == CH_DQUOTE && r.state.char_open) begin
            r.state.char_open = 1'b0;
        end
        if (r.state.char_open) begin
            col = ATTR_CHAR;
        end
        if (b == CH_SQUOTE) begin
            r.state.char_open = !r.state.char_open;
            col = ATTR_CHAR;
        end

        if (r.state.string_open) begin
            col = ATTR_STRING;
        end
        if (b == CH_DQUOTE) begin
            r.state.string_open = !r.state.string_open;
            col = ATTR_STRING;
        end

        r.state.close_next = 1'b0;
        if (closing) begin
            col = ATTR_COMMENT;
        end
        if (not_last) begin
            if (b == CH_SLASH && nxt == CH_STAR) begin
                r.state.block_open = 1'b1;
            end
            if (r.state.block_open) begin
                col = ATTR_COMMENT;
            end
            if (b == CH_STAR && nxt == CH_SLASH) begin
                r.state.block_open = 1'b0;
                r.state.close_next = 1'b1;
            end
            if (b == CH_SLASH && nxt == CH_SLASH) begin
                r.state.line_active = 1'b1;
            end
        end
        if (r.state.line_active) begin
            col = ATTR_COMMENT;
        end

        if (col == ATTR_DEFAULT) begin
            col = ATTR_IDENT;
        end

        // A newline ends every row-bound construct; the block comment lives on.
        if (!not_last) begin
            r.state.preproc_row = 1'b0;
            r.state.char_open   = 1'b0;
            r.state.string_open = 1'b0;
            r.state.line_active = 1'b0;
            r.state.close_next  = 1'b0;
        end
        r.attr = col;
        return r;
    endfunction

endpackage

FILE: hdl/c_source_syntax_colorizer.sv
`timescale 1ns / 1ps
// ============================================================================
// c_source_syntax_colorizer: console coloring of C source text
// Gives every byte of a C source stream a console color attribute, with one
// byte of lookahead so that comment openers and closers can be recognized.
// ============================================================================
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+----------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_text_byte, i_end_of_text
//  output  | out       | o_out_valid / i_out_ready | o_colored_byte, o_attribute,
//          |           |                           | o_final_result
//
//  While ready, one byte is taken per cycle, back to back. A byte's color
//  is decided when the next byte arrives, so its result is queued one transfer
//  late; a byte marked end of text queues its own result and the held one
//  together. The input is ready while at least two of the DEPTH queue entries
//  are free, so it stalls only after the output side has held off for a while.
//  Reset is synchronous and active low; it empties the queue and restarts text.
//
module c_source_syntax_colorizer #(
    parameter int DEPTH = cssc_pkg::RESULT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_colored_byte,
    output logic [3:0] o_attribute,
    output logic       o_final_result
);

    // Held byte waiting for its successor, and the scanner state before it.
    logic [7:0]        r_pending_byte;
    logic              r_pending_valid;
    cssc_pkg::t_scan   r_scan;

    logic              accept;
    cssc_pkg::t_colour held_col;
    cssc_pkg::t_colour last_col;
    cssc_pkg::t_scan   scan_after_held;
    cssc_pkg::t_result held_res;
    cssc_pkg::t_result last_res;
    cssc_pkg::t_result entry0;
    cssc_pkg::t_result entry1;
    logic [1:0]        push_count;
    cssc_pkg::t_result out_entry;

    assign accept = i_in_valid && o_in_ready;

    // The held byte is colored now that its successor is known. The final
    // byte is colored right after it, as if followed by a plain byte.
    assign held_col        = cssc_pkg::colour_byte(r_pending_byte, i_text_byte, r_scan);
    assign scan_after_held = r_pending_valid ? held_col.state : r_scan;
    assign last_col        = cssc_pkg::colour_byte(i_text_byte, cssc_pkg::CH_NONE,
                                                   scan_after_held);

    assign held_res = '{colored_byte: r_pending_byte, attribute: held_col.attr,
                        final_result: 1'b0};
    assign last_res = '{colored_byte: i_text_byte, attribute: last_col.attr,
                        final_result: 1'b1};

    // Pack the results of this transfer into the front queue slots.
    always_comb begin
        entry0     = r_pending_valid ? held_res : last_res;
        entry1     = last_res;
        push_count = 2'd0;
        if (accept) begin
            push_count = {1'b0, r_pending_valid} + {1'b0, i_end_of_text};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_valid <= 1'b0;
            r_pending_byte  <= '0;
            r_scan          <= cssc_pkg::SCAN_RESET;
        end else if (accept) begin
            if (i_end_of_text) begin
                // End of text: everything goes back to the start state.
                r_pending_valid <= 1'b0;
                r_pending_byte  <= '0;
                r_scan          <= cssc_pkg::SCAN_RESET;
            end else begin
                r_pending_valid <= 1'b1;
                r_pending_byte  <= i_text_byte;
                r_scan          <= scan_after_held;
            end
        end
    end

    cssc_result_fifo #(
        .DEPTH (DEPTH)
    ) u_result_fifo (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push_count      (push_count),
        .i_entry0          (entry0),
        .i_entry1_unused_n (1'b0),
        .i_entry1          (entry1),
        .o_room_for_two    (o_in_ready),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_entry           (out_entry)
    );

    assign o_colored_byte = out_entry.colored_byte;
    assign o_attribute    = out_entry.attribute;
    assign o_final_result = out_entry.final_result;

endmodule

FILE: hdl/cssc_result_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// cssc_result_fifo: result queue of the colorizer
// A small circular queue that takes up to two result items per cycle and
// hands out one per transfer on a valid/ready output.
// ============================================================================
module cssc_result_fifo #(
    parameter int DEPTH = cssc_pkg::RESULT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_count,
    input  cssc_pkg::t_result  i_entry0,
    input  logic               i_entry1_unused_n,
    input  cssc_pkg::t_result  i_entry1,
    output logic               o_room_for_two,
    output logic               o_valid,
    input  logic               i_ready,
    output cssc_pkg::t_result  o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cssc_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;
    logic [PW-1:0] wr1;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop            = (r_count != '0) && i_ready;
    assign wr1            = ptr_inc(r_wr);
    assign o_valid        = (r_count != '0);
    assign o_entry        = r_mem[r_rd];
    assign o_room_for_two = (r_count <= CW'(DEPTH - 2));

    always_comb begin
        n_rd    = pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + CW'(i_push_count) - CW'(pop);
        case (i_push_count)
            2'd0:    n_wr = r_wr;
            2'd1:    n_wr = wr1;
            2'd2:    n_wr = ptr_inc(wr1);
            default: n_wr = r_wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_entry0;
        end
        if (i_push_count == 2'd2 && !i_entry1_unused_n) begin
            r_mem[wr1] <= i_entry1;
        end
    end

endmodule

FILE: hdl/cssc_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// cssc_checker: port-level assertions for the colorizer
// Watches the top level's ports over time and is bound to every instance.
// ============================================================================
module cssc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_text_byte,
    input logic       i_end_of_text,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_colored_byte,
    input logic [3:0] o_attribute,
    input logic       o_final_result
);

    // Reset leaves no result behind.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_colored_byte) && $stable(o_attribute)
            && $stable(o_final_result))
        else $error("stalled result changed or vanished");

    // The end of text always leaves at least the final result queued.
    a_flush_queues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_end_of_text |=> o_out_valid)
        else $error("end of text accepted but no result queued");

    // Input backpressure only ever comes from results waiting at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind c_source_syntax_colorizer cssc_checker u_cssc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_text_byte    (i_text_byte),
    .i_end_of_text  (i_end_of_text),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_colored_byte (o_colored_byte),
    .o_attribute    (o_attribute),
    .o_final_result (o_final_result)
);

FILE: verif/c_source_syntax_colorizer_test.sv
`timescale 1ns / 1ps
// ============================================================================
// c_source_syntax_colorizer_test: self-checking bench for the C colorizer
// Streams directed and randomly built C-like text through the block and
// compares every colored byte against an independent color predictor.
// ============================================================================

class color_scoreboard;

    // Scanner state as it stands after the last byte that was colored.
    bit [7:0] held_byte;
    bit       byte_held;
    bit       row_start;
    bit       preproc_row;
    bit       char_open;
    bit       string_open;
    bit       block_open;
    bit       line_comment;
    bit       closing_slash;

    cssc_pkg::t_result expected_colors[$];
    int                errors;

    function new();
        errors = 0;
        restart_text();
    endfunction

    function void restart_text();
        held_byte     = cssc_pkg::CH_NONE;
        byte_held     = 1'b0;
        row_start     = 1'b1;
        preproc_row   = 1'b0;
        char_open     = 1'b0;
        string_open   = 1'b0;
        block_open    = 1'b0;
        line_comment  = 1'b0;
        closing_slash = 1'b0;
    endfunction

    function int outstanding();
        return expected_colors.size();
    endfunction

    // Color of byte b, knowing the byte that follows it. Rules are applied
    // lowest priority first so later ones override.
    function bit [3:0] predict_color(bit [7:0] b, bit [7:0] nxt);
        bit [3:0] col;
        bit       ends_row;
        bit       was_closing;
        col         = cssc_pkg::ATTR_DEFAULT;
        ends_row    = (b == cssc_pkg::CH_NEWLINE);
        was_closing = closing_slash;

        if (row_start) begin
            preproc_row = (b == cssc_pkg::CH_HASH);
        end
        row_start = ends_row;

        case (b)
            "!", "%", "&", "*", "+", ",", "-", ".", "/",
            ":", ";", "<", "=", ">", "?", "^", "|", "~": col = cssc_pkg::ATTR_OPERATOR;
            "(", ")", "[", "]", "{", "}": col = cssc_pkg::ATTR_BRACKET;
            default: begin
                if (b >= "0" && b <= "9") begin
                    col = cssc_pkg::ATTR_DIGIT;
                end
            end
        endcase

        if (preproc_row && b == cssc_pkg::CH_LESS) begin
            preproc_row = 1'b0;
        end
        if (preproc_row) begin
            col = cssc_pkg::ATTR_PREPROC;
        end

        if (b == cssc_pkg::CH_DQUOTE) begin
            char_open = 1'b0;
        end
        if (char_open) begin
            col = cssc_pkg::ATTR_CHAR;
        end
        if (b == cssc_pkg::CH_SQUOTE) begin
            char_open = !char_open;
            col = cssc_pkg::ATTR_CHAR;
        end

        if (string_open) begin
            col = cssc_pkg::ATTR_STRING;
        end
        if (b == cssc_pkg::CH_DQUOTE) begin
            string_open = !string_open;
            col = cssc_pkg::ATTR_STRING;
        end

        closing_slash = 1'b0;
        if (was_closing) begin
            col = cssc_pkg::ATTR_COMMENT;
        end
        if (!ends_row) begin
            if (b == cssc_pkg::CH_SLASH && nxt == cssc_pkg::CH_STAR) begin
                block_open = 1'b1;
            end
            if (block_open) begin
                col = cssc_pkg::ATTR_COMMENT;
            end
            if (b == cssc_pkg::CH_STAR && nxt == cssc_pkg::CH_SLASH) begin
                block_open    = 1'b0;
                closing_slash = 1'b1;
            end
            if (b == cssc_pkg::CH_SLASH && nxt == cssc_pkg::CH_SLASH) begin
                line_comment = 1'b1;
            end
        end
        if (line_comment) begin
            col = cssc_pkg::ATTR_COMMENT;
        end

        if (col == cssc_pkg::ATTR_DEFAULT) begin
            col = cssc_pkg::ATTR_IDENT;
        end

        if (ends_row) begin
            preproc_row   = 1'b0;
            char_open     = 1'b0;
            string_open   = 1'b0;
            line_comment  = 1'b0;
            closing_slash = 1'b0;
        end
        return col;
    endfunction

    // An accepted byte settles the color of the byte held before it; an end
    // of text also settles its own and starts a fresh text.
    function void note_byte(bit [7:0] b, bit last);
        if (byte_held) begin
            expected_colors.push_back('{colored_byte: held_byte,
                                        attribute: predict_color(held_byte, b),
                                        final_result: 1'b0});
        end
        held_byte = b;
        byte_held = 1'b1;
        if (last) begin
            expected_colors.push_back('{colored_byte: b,
                                        attribute: predict_color(b, cssc_pkg::CH_NONE),
                                        final_result: 1'b1});
            restart_text();
        end
    endfunction

    function void check_color(cssc_pkg::t_result got);
        cssc_pkg::t_result want;
        if (expected_colors.size() == 0) begin
            $error("unexpected result: colored_byte %h attribute %h final_result %b",
                   got.colored_byte, got.attribute, got.final_result);
            errors++;
            return;
        end
        want = expected_colors.pop_front();
        if (got.colored_byte !== want.colored_byte) begin
            $error("colored_byte: expected %h, actual %h", want.colored_byte,
                   got.colored_byte);
            errors++;
        end
        if (got.attribute !== want.attribute) begin
            $error("attribute: expected %h, actual %h", want.attribute, got.attribute);
            errors++;
        end
        if (got.final_result !== want.final_result) begin
            $error("final_result: expected %b, actual %b", want.final_result,
                   got.final_result);
            errors++;
        end
    endfunction

endclass

module c_source_syntax_colorizer_test;

    // Roughly how many bytes of text the run pushes through the block.
    localparam int TEXT_BYTES = 1900;
    // Cycles the receiver refuses results once, long enough to fill the
    // result queue and push back on the input.
    localparam int LONG_HOLD = 150;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Settling time after the last expected result has come back.
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_text_byte    = 8'h00;
    logic       i_end_of_text  = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready    = 1'b0;
    logic [7:0] o_colored_byte;
    logic [3:0] o_attribute;
    logic       o_final_result;

    color_scoreboard sb;

    int  bytes_sent   = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    // While set, the sender offers bytes back to back.
    bit  sender_calm  = 1'b0;
    bit  hold_active  = 1'b0;

    c_source_syntax_colorizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_colored_byte (o_colored_byte),
        .o_attribute    (o_attribute),
        .o_final_result (o_final_result)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Monitor and watchdog. Everything is sampled at the rising edge before
    // the nonblocking updates of that edge land, so the values seen are the
    // ones the block saw. Input is noted before output is checked, so a
    // result can never be checked ahead of the byte that caused it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_byte(i_text_byte, i_end_of_text);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_color('{colored_byte: o_colored_byte, attribute: o_attribute,
                                 final_result: o_final_result});
                results_seen++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Result receiver: a random stall before each result, calm stretches
    // with no stalls at all, and one long hold-off partway through.
    initial begin
        int  stall;
        bit  calm;
        bit  hold_done;
        calm      = 1'b0;
        hold_done = 1'b0;
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (!hold_done && results_seen >= 400) begin
                hold_active = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end
            if ($urandom_range(0, 39) == 0) begin
                calm = !calm;
            end
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!o_out_valid);
        end
    end

    // Offers one byte after a random idle gap and returns at the edge where
    // the transfer happens. A back-to-back byte keeps valid high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (sender_calm || hold_active) ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= last;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        bytes_sent++;
    endtask

    // Stops offering until every result owed so far has come back. It always
    // waits on the clock first, so the next offer never lands in the same time step.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.outstanding() != 0);
    endtask

    function automatic logic [7:0] pick_from(input string chars);
        return chars[$urandom_range(0, chars.len() - 1)];
    endfunction

    // Builds one random lexical piece of C-like text. Most pieces are well
    // formed so that comments, strings and preprocessor rows really open and
    // close; a few are unterminated, stray or arbitrary bytes.
    task automatic build_snippet(ref logic [7:0] text[$]);
        string letters;
        string ops;
        string body;
        int    n;
        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        ops     = "!%&*+,-./:;<=>?^|~";
        body    = "ab 1+*/\"'#<(\n";
        case ($urandom_range(0, 11))
            0: begin
                n = $urandom_range(1, 6);
                repeat (n) text.push_back(pick_from(letters));
            end
            1: begin
                n = $urandom_range(1, 4);
                repeat (n) text.push_back(pick_from("0123456789"));
            end
            2: begin
                n = $urandom_range(1, 3);
                repeat (n) text.push_back(pick_from(ops));
            end
            3: text.push_back(pick_from("()[]{}"));
            4: begin
                text.push_back(cssc_pkg::CH_DQUOTE);
                n = $urandom_range(0, 5);
                repeat (n) text.push_back(pick_from("ab9 +('/*<"));
                if ($urandom_range(0, 4) != 0) begin
                    text.push_back(cssc_pkg::CH_DQUOTE);
                end
            end
            5: begin
                text.push_back(cssc_pkg::CH_SQUOTE);
                text.push_back(pick_from("a0\"\\ /"));
                if ($urandom_range(0, 4) != 0) begin
                    text.push_back(cssc_pkg::CH_SQUOTE);
                end
            end
            6: begin
                text.push_back(cssc_pkg::CH_SLASH);
                text.push_back(cssc_pkg::CH_STAR);
                n = $urandom_range(0, 8);
                repeat (n) text.push_back(pick_from(body));
                if ($urandom_range(0, 5) != 0) begin
                    text.push_back(cssc_pkg::CH_STAR);
                    text.push_back(cssc_pkg::CH_SLASH);
                end
            end
            7: begin
                text.push_back(cssc_pkg::CH_SLASH);
                text.push_back(cssc_pkg::CH_SLASH);
                n = $urandom_range(0, 6);
                repeat (n) text.push_back(pick_from("ab 1+*/\"'#<("));
                text.push_back(cssc_pkg::CH_NEWLINE);
            end
            8: begin
                text.push_back(cssc_pkg::CH_NEWLINE);
                text.push_back(cssc_pkg::CH_HASH);
                n = $urandom_range(1, 5);
                repeat (n) text.push_back(pick_from(letters));
                text.push_back(" ");
                if ($urandom_range(0, 2) != 0) begin
                    text.push_back(cssc_pkg::CH_LESS);
                    text.push_back(pick_from(letters));
                    text.push_back(">");
                end else begin
                    text.push_back(pick_from("\"1(*"));
                end
                text.push_back(cssc_pkg::CH_NEWLINE);
            end
            9: text.push_back(pick_from(" \n\n\t"));
            10: begin
                n = $urandom_range(1, 3);
                repeat (n) text.push_back(8'($urandom_range(0, 255)));
            end
            default: text.push_back(pick_from("/*'\"#<"));
        endcase
    endtask

    initial begin
        string      directed;
        logic [7:0] text[$];
        bit         drained_midway;
        sb             = new();
        drained_midway = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed text. It opens with an end of text while nothing is held,
        // then walks through a preprocessor row cut at '<', a character
        // literal closed by a double quote, a string, a block comment that
        // spans a newline, a digit, a bracket, an operator, a line comment,
        // the byte extremes, and a final byte that is not a newline.
        send_byte(8'h00, 1'b1);
        directed = "#i<x>\n'a\"b\"\n/*\n*/9(+//";
        for (int i = 0; i < directed.len(); i++) begin
            send_byte(directed[i], 1'b0);
        end
        send_byte(8'hFF, 1'b0);
        send_byte(cssc_pkg::CH_NEWLINE, 1'b0);
        send_byte(cssc_pkg::CH_STAR, 1'b1);
        wait_for_drain();

        // Random text, with an occasional end of text anywhere in it.
        while (bytes_sent < TEXT_BYTES) begin
            if ($urandom_range(0, 29) == 0) begin
                sender_calm = !sender_calm;
            end
            if (!drained_midway && bytes_sent >= TEXT_BYTES / 2) begin
                wait_for_drain();
                drained_midway = 1'b1;
            end
            build_snippet(text);
            while (text.size() != 0) begin
                send_byte(text.pop_front(), $urandom_range(0, 79) == 0);
            end
        end
        // Close the text so the held byte is flushed too.
        send_byte(cssc_pkg::CH_NEWLINE, 1'b1);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
